[design/ikht_pkg.sv]
// shared types, constants and codes for the integer key hash table
// no dependencies
`timescale 1ns / 1ps
package ikht_pkg;

  localparam int MAX_BUCKETS  = 64;
  localparam int BUCKET_DEPTH = 8;
  localparam int SLOT_TOTAL   = MAX_BUCKETS * BUCKET_DEPTH;
  localparam int BKT_W        = $clog2(MAX_BUCKETS);
  localparam int SLOT_W       = $clog2(BUCKET_DEPTH);
  localparam int ADDR_W       = BKT_W + SLOT_W;
  localparam int CFG_W        = 7;
  localparam int CNT_W        = 10;
  localparam int KEY_W        = 32;
  localparam int DIV_STEPS    = KEY_W;

  localparam logic [KEY_W-1:0] HASH_MUL = 32'd101;
  localparam logic [KEY_W-1:0] HASH_ADD = 32'd65537;
  localparam logic [CFG_W-1:0] BUCKETS_RESET = CFG_W'(MAX_BUCKETS);

  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] data_out;
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
  } rsp_word_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_DIV, S_ROWRD, S_SLOTRD, S_SLOTCMP,
    S_VALRD, S_VALWAIT, S_COMMIT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic hash;
    logic div_step;
    logic row_read;
    logic slot_read;
    logic slot_cmp;
    logic val_read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
    logic slot_last;
    logic out_busy;
  } sts_t;

endpackage

[design/integer_key_hash_table_unit.sv]
// top level of the integer key hash table: controller plus datapath
// depends on ikht_pkg, ikht_ctrl, ikht_dp
`timescale 1ns / 1ps
// Key/value table with 32-bit keys, 64 buckets of 8 slots. Requests are put,
// get and remove; each gives one response word with found flag, value,
// status and the entry count. After reset the valid store is swept clear,
// one bucket a cycle, and no request is taken meanwhile. An item passes
// through the hash multiply, the bit serial modulo by the bucket count, the
// bucket row read, the read and compare of the eight slots over the single
// key memory read port, the value read and the commit, then goes back to
// idle, where the next request is taken; the commit waits while an earlier
// response is held by rsp_stall. A response may wait in its output register
// while the next request is accepted. The user must write bucket_count only
// while the unit is idle; the block itself does not enforce it.
module integer_key_hash_table_unit import ikht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_word_t        req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_word_t        rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req_stall = !in_ready;
  assign cfg_ready = 1'b1;

  ikht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  ikht_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[design/ikht_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps
module ikht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ikht_ctrl.sv]
// sequencing state machine for the hash table
// depends on ikht_pkg
`timescale 1ns / 1ps
module ikht_ctrl import ikht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_ROWRD;
      end
      S_ROWRD: begin
        cmd.row_read = 1'b1;
        state_next   = S_SLOTRD;
      end
      S_SLOTRD: begin
        cmd.slot_read = 1'b1;
        state_next    = S_SLOTCMP;
      end
      S_SLOTCMP: begin
        cmd.slot_cmp = 1'b1;
        state_next   = sts.slot_last ? S_VALRD : S_SLOTRD;
      end
      S_VALRD: begin
        cmd.val_read = 1'b1;
        state_next   = S_VALWAIT;
      end
      S_VALWAIT: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register is free
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[design/ikht_dp.sv]
// datapath: hash, serial modulo, bucket scan, entry stores and result register
// depends on ikht_pkg and ikht_ram
`timescale 1ns / 1ps
module ikht_dp import ikht_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  req_word_t        req,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_word_t        rsp
);

  logic [CFG_W-1:0]          bucket_count;
  logic [CNT_W-1:0]          stored_total;
  logic [BKT_W-1:0]          clr_cnt;
  logic [1:0]                req_type;
  logic [KEY_W-1:0]          key;
  logic [KEY_W-1:0]          value;
  logic [CFG_W-1:0]          divisor;
  logic [KEY_W-1:0]          hash;
  logic [CFG_W-1:0]          rem;
  logic [$clog2(DIV_STEPS)-1:0] div_cnt;
  logic [SLOT_W-1:0]         slot;
  logic [SLOT_W-1:0]         hit;
  logic [SLOT_W-1:0]         free_slot;
  logic                      found;
  logic                      have_free;

  logic [BKT_W-1:0]          bucket;
  logic [CFG_W:0]            rem_sh;
  logic [CFG_W-1:0]          eff;
  logic [BUCKET_DEPTH-1:0]   row;
  logic [BUCKET_DEPTH-1:0]   row_new;
  logic [KEY_W-1:0]          key_rd;
  logic [KEY_W-1:0]          val_rd;
  logic                      vld_we;
  logic [BKT_W-1:0]          vld_waddr;
  logic [BUCKET_DEPTH-1:0]   vld_wdata;
  logic                      row_we;
  logic                      key_we;
  logic                      val_we;
  logic [ADDR_W-1:0]         ent_waddr;
  logic [CNT_W-1:0]          total_next;
  rsp_word_t                 res;

  assign bucket = rem[BKT_W-1:0];
  assign rem_sh = {rem, hash[KEY_W-1]};

  // zero acts as one bucket, anything above the maximum is clamped
  always_comb begin
    eff = bucket_count;
    if (bucket_count == '0) eff = CFG_W'(1);
    else if (bucket_count > CFG_W'(MAX_BUCKETS)) eff = CFG_W'(MAX_BUCKETS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKETS_RESET;
      clr_cnt      <= '0;
    end else begin
      if (cfg_we) bucket_count <= cfg_data;
      if (cmd.clear_step) clr_cnt <= clr_cnt + BKT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type <= req.req_type;
      key      <= req.key;
      value    <= req.value;
      divisor  <= eff;
    end
    if (cmd.hash) begin
      hash    <= KEY_W'(key * HASH_MUL) + HASH_ADD;
      rem     <= '0;
      div_cnt <= '0;
    end
    // restoring division, one quotient bit per cycle
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, divisor}) rem <= CFG_W'(rem_sh - {1'b0, divisor});
      else                           rem <= CFG_W'(rem_sh);
      hash    <= hash << 1;
      div_cnt <= div_cnt + $clog2(DIV_STEPS)'(1);
    end
    if (cmd.row_read) begin
      slot      <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
    end
    if (cmd.slot_cmp) begin
      if (row[slot]) begin
        if (!found && key_rd == key) begin
          found <= 1'b1;
          hit   <= slot;
        end
      end else if (!have_free) begin
        have_free <= 1'b1;
        free_slot <= slot;
      end
      slot <= slot + SLOT_W'(1);
    end
  end

  assign sts.clear_last = (clr_cnt == BKT_W'(MAX_BUCKETS - 1));
  assign sts.div_last   = (div_cnt == $clog2(DIV_STEPS)'(DIV_STEPS - 1));
  assign sts.slot_last  = (slot == SLOT_W'(BUCKET_DEPTH - 1));
  assign sts.out_busy   = rsp_valid && rsp_stall;

  // commit decision
  always_comb begin
    row_new    = row;
    row_we     = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    ent_waddr  = {bucket, hit};
    total_next = stored_total;
    res.found       = found;
    res.data_out    = '0;
    res.status      = ST_OK;
    case (req_type)
      REQ_PUT: begin
        if (value == '0) begin
          res.status = ST_ZERO;
        end else if (found) begin
          val_we = 1'b1;
        end else if (have_free) begin
          key_we             = 1'b1;
          val_we             = 1'b1;
          ent_waddr          = {bucket, free_slot};
          row_new[free_slot] = 1'b1;
          row_we             = 1'b1;
          total_next         = stored_total + CNT_W'(1);
        end else begin
          res.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          res.data_out = val_rd;
          row_new[hit] = 1'b0;
          row_we       = 1'b1;
          if (stored_total != '0) total_next = stored_total - CNT_W'(1);
        end
      end
      default: begin
        if (found) res.data_out = val_rd;
      end
    endcase
    res.entry_count = total_next;
  end

  assign vld_we    = cmd.clear_step || (cmd.commit && row_we);
  assign vld_waddr = cmd.clear_step ? clr_cnt : bucket;
  assign vld_wdata = cmd.clear_step ? '0 : row_new;

  ikht_ram #(.WIDTH(BUCKET_DEPTH), .DEPTH(MAX_BUCKETS)) u_valid (
    .clk   (clk),
    .we    (vld_we),
    .waddr (vld_waddr),
    .wdata (vld_wdata),
    .re    (cmd.row_read),
    .raddr (bucket),
    .rdata (row)
  );

  ikht_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_TOTAL)) u_keys (
    .clk   (clk),
    .we    (cmd.commit && key_we),
    .waddr (ent_waddr),
    .wdata (key),
    .re    (cmd.slot_read),
    .raddr ({bucket, slot}),
    .rdata (key_rd)
  );

  ikht_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_TOTAL)) u_values (
    .clk   (clk),
    .we    (cmd.commit && val_we),
    .waddr (ent_waddr),
    .wdata (value),
    .re    (cmd.val_read),
    .raddr ({bucket, hit}),
    .rdata (val_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_total <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cmd.commit) begin
        stored_total <= total_next;
        rsp_valid    <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) rsp <= res;
  end

endmodule
